// ===== rtl/brfe_pkg.sv =====
// Shared types, codes and helper functions of the bitplane rectangle fill engine.
// Used by brfe_core, brfe_fifo and bitplane_rect_fill_engine_top; depends on nothing else.
package brfe_pkg;

    // Raster operation codes held in the raster_op register.
    localparam logic [1:0] ROP_OR     = 2'd0;
    localparam logic [1:0] ROP_XOR    = 2'd1;
    localparam logic [1:0] ROP_ANDNOT = 2'd2;

    // Input selector codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // Configuration register indexes, decoded from paddr[2].
    localparam logic CFG_RASTER_OP = 1'b0;
    localparam logic CFG_STRIDE    = 1'b1;

    localparam logic [15:0] STRIDE_RESET   = 16'h0100;
    localparam logic [7:0]  INNER_FULL_MASK = 8'hFF;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [15:0] tile_address;
        logic [7:0]  inner_columns;
        logic [7:0]  left_mask;
        logic [7:0]  right_mask;
        logic [7:0]  row_count;
        logic [7:0]  read_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] mem_address;
        logic        is_write;
        logic [7:0]  write_data;
        logic        last;
    } result_t;

    // Up to two results produced by one accepted transaction.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic logic [7:0] combine(input logic [1:0] rop, input logic [7:0] old,
                                           input logic [7:0] mask);
        logic [7:0] r;
        case (rop)
            ROP_OR:     r = old | mask;
            ROP_XOR:    r = old ^ mask;
            ROP_ANDNOT: r = old & ~mask;
            default:    r = old;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bitplane_rect_fill_engine_top.sv =====
// Top level of the bitplane rectangle fill engine: stream ports, APB registers,
// sequencer and result queue. Depends on brfe_pkg, brfe_core and brfe_fifo.
//
//   Channel  Direction  Carries
//   s_       in         start commands and returned read bytes (tuser = func)
//   m_       out        read requests and writes (tuser = is_write, tlast = last)
//   APB      in/out     raster_op at 0x0, column_stride at 0x4
//
// An input transaction is accepted in any cycle in which the result queue has
// room for two results, so items may follow each other in consecutive cycles.
// Results leave one per cycle while m_tready is high; a data byte yields its
// write and the next read (the final byte its write only), so a stream of data
// bytes is paced by the single result port, each result held in the queue.
// Reset is synchronous and active low; it idles the sequencer, empties the queue
// and restores raster_op to OR and column_stride to 256. No clearing pass.
// Stalls on m_ only fill the four-entry queue; s_tready drops when fewer than
// two slots are free and rises again as results drain.
module bitplane_rect_fill_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] tile_address, [23:16] inner_columns, [31:24] left_mask,
    // [39:32] right_mask, [47:40] row_count, [55:48] read_byte
    input  logic [55:0] s_tdata,
    // [0] func
    input  logic        s_tuser,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] mem_address, [23:16] write_data
    output logic [23:0] m_tdata,
    // [0] is_write
    output logic        m_tuser,
    output logic        m_tlast
);

    logic [1:0]  raster_op_reg;
    logic [15:0] stride_reg;
    logic        cfg_write;

    brfe_pkg::in_item_t item;
    brfe_pkg::push_t    push;
    brfe_pkg::result_t  head;
    logic               s_fire;
    logic               m_fire;
    logic               busy;
    logic               room_for_two;
    logic [brfe_pkg::FIFO_CW-1:0] level;

    // The APB port never stalls. Low address bits are ignored, so paddr[2]
    // selects the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raster_op_reg <= brfe_pkg::ROP_OR;
            stride_reg    <= brfe_pkg::STRIDE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == brfe_pkg::CFG_RASTER_OP) begin
                raster_op_reg <= pwdata[1:0];
            end else begin
                stride_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            brfe_pkg::CFG_RASTER_OP: prdata = {30'd0, raster_op_reg};
            brfe_pkg::CFG_STRIDE:    prdata = {16'd0, stride_reg};
            default:                 prdata = '0;
        endcase
    end

    // The input fields are unpacked from tdata in the documented order.
    assign item.tile_address  = s_tdata[15:0];
    assign item.inner_columns = s_tdata[23:16];
    assign item.left_mask     = s_tdata[31:24];
    assign item.right_mask    = s_tdata[39:32];
    assign item.row_count     = s_tdata[47:40];
    assign item.read_byte     = s_tdata[55:48];

    assign s_tready = room_for_two;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    // The sequencer steps its state on each accepted transaction and hands the
    // results it produces straight into the queue's registers.
    brfe_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (s_fire),
        .func          (s_tuser),
        .item          (item),
        .raster_op     (raster_op_reg),
        .column_stride (stride_reg),
        .push          (push),
        .busy          (busy)
    );

    brfe_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .pop          (m_fire),
        .head         (head),
        .not_empty    (m_tvalid),
        .room_for_two (room_for_two),
        .level        (level)
    );

    assign m_tdata = {head.write_data, head.mem_address};
    assign m_tuser = head.is_write;
    assign m_tlast = head.last;

    // The queue never holds more entries than it has slots.
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= brfe_pkg::FIFO_CW'(brfe_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // The final-write marker is only ever carried by a write transaction.
    a_last_is_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("last flag on a read request");

    // A start accepted while idle opens a fill on the next cycle.
    a_start_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_tuser == brfe_pkg::FUNC_START) && !busy |=> busy)
        else $error("start command did not open a fill");

    // A data byte that queues only its final write closes the fill.
    a_close_has_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && busy && (s_tuser == brfe_pkg::FUNC_DATA) && (push.count == 2'd1)
        |=> !busy)
        else $error("fill did not close after its final write");

endmodule

// ===== rtl/brfe_core.sv =====
// Fill sequencer: rectangle state registers and the per-transaction step logic.
// Depends on brfe_pkg.
module brfe_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  logic               func,
    input  brfe_pkg::in_item_t item,
    input  logic [1:0]         raster_op,
    input  logic [15:0]        column_stride,
    output brfe_pkg::push_t    push,
    output logic               busy
);

    logic        busy_reg, busy_next;
    logic [15:0] base_reg, base_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  cbf_reg, cbf_next;
    logic [7:0]  first_mask_reg, first_mask_next;
    logic [7:0]  last_mask_reg, last_mask_next;
    logic [7:0]  rows_reg, rows_next;

    logic [15:0] cur_addr;
    logic [7:0]  cur_mask;
    logic [7:0]  next_row;
    logic [15:0] stepped_base;

    assign cur_addr     = {base_reg[15:8], base_reg[7:0] + row_reg};
    assign next_row     = row_reg + 8'd1;
    assign stepped_base = base_reg + column_stride;

    always_comb begin
        if (col_reg == 8'd0) begin
            cur_mask = first_mask_reg;
        end else if (col_reg == cbf_reg) begin
            cur_mask = last_mask_reg;
        end else begin
            cur_mask = brfe_pkg::INNER_FULL_MASK;
        end
    end

    always_comb begin
        busy_next       = busy_reg;
        base_next       = base_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cbf_next        = cbf_reg;
        first_mask_next = first_mask_reg;
        last_mask_next  = last_mask_reg;
        rows_next       = rows_reg;
        push            = '0;

        if (fire) begin
            if (func == brfe_pkg::FUNC_START) begin
                if (!busy_reg) begin
                    base_next       = item.tile_address;
                    cbf_next        = item.inner_columns;
                    rows_next       = item.row_count;
                    first_mask_next = (item.inner_columns == 8'd0) ?
                                      (item.left_mask & item.right_mask) : item.left_mask;
                    last_mask_next  = item.right_mask;
                    row_next        = 8'd0;
                    col_next        = 8'd0;
                    busy_next       = 1'b1;
                    push.count      = 2'd1;
                    push.res0       = '{mem_address: item.tile_address, is_write: 1'b0,
                                        write_data: 8'd0, last: 1'b0};
                end
            end else if (busy_reg) begin
                push.res0 = '{mem_address: cur_addr, is_write: 1'b1,
                              write_data: brfe_pkg::combine(raster_op, item.read_byte,
                                                            cur_mask),
                              last: 1'b0};
                if (next_row == rows_reg) begin
                    row_next = 8'd0;
                    if (col_reg == cbf_reg) begin
                        // Final byte of the rectangle: write only.
                        busy_next      = 1'b0;
                        push.count     = 2'd1;
                        push.res0.last = 1'b1;
                    end else begin
                        col_next   = col_reg + 8'd1;
                        base_next  = stepped_base;
                        push.count = 2'd2;
                        push.res1  = '{mem_address: stepped_base, is_write: 1'b0,
                                       write_data: 8'd0, last: 1'b0};
                    end
                end else begin
                    row_next   = next_row;
                    push.count = 2'd2;
                    push.res1  = '{mem_address: {base_reg[15:8], base_reg[7:0] + next_row},
                                   is_write: 1'b0, write_data: 8'd0, last: 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            base_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            cbf_reg        <= '0;
            first_mask_reg <= '0;
            last_mask_reg  <= '0;
            rows_reg       <= '0;
        end else begin
            busy_reg       <= busy_next;
            base_reg       <= base_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            cbf_reg        <= cbf_next;
            first_mask_reg <= first_mask_next;
            last_mask_reg  <= last_mask_next;
            rows_reg       <= rows_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/brfe_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle on each pop.
// Depends on brfe_pkg.
module brfe_fifo (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  brfe_pkg::push_t                push,
    input  logic                           pop,
    output brfe_pkg::result_t              head,
    output logic                           not_empty,
    output logic                           room_for_two,
    output logic [brfe_pkg::FIFO_CW-1:0]   level
);

    brfe_pkg::result_t mem [brfe_pkg::FIFO_DEPTH];

    logic [brfe_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [brfe_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [brfe_pkg::FIFO_CW-1:0] count_reg, count_next;
    logic [brfe_pkg::FIFO_AW-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + brfe_pkg::FIFO_AW'(1);
    assign wr_ptr_next  = wr_ptr_reg + brfe_pkg::FIFO_AW'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + brfe_pkg::FIFO_AW'(pop);
    assign count_next   = count_reg + brfe_pkg::FIFO_CW'(push.count)
                          - brfe_pkg::FIFO_CW'(pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= brfe_pkg::FIFO_CW'(brfe_pkg::FIFO_DEPTH - 2));
    assign level        = count_reg;

endmodule
